>>> rtl/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg: shared definitions for the sorted max-priority queue
// Sizes, status codes and the structs that pass between the cell chain and
// the top level.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_W     = $clog2(DEPTH + 1);
  localparam int STATUS_W    = 2;

  // Result payload: popped, head, count, status, padded to whole bytes.
  localparam int OUT_FIELDS_W = 2 * VALUE_WIDTH + COUNT_W + STATUS_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int IN_DATA_W    = ((VALUE_WIDTH + 7) / 8) * 8;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  // Operation broadcast to every cell in the chain.
  typedef struct packed {
    logic   push_en;
    logic   pop_en;
    value_t new_value;
  } cell_ctrl_t;

  // Link from a cell to the cell behind it (higher index).
  typedef struct packed {
    logic   greater;  // the new value belongs at or before this cell
    value_t value;    // the value currently held by this cell
  } cell_link_t;

endpackage

>>> rtl/smpq_cell.sv
// ----------------------------------------------------------------------------
// smpq_cell: one storage cell of the sorted chain
// Holds one value. On a push it keeps, takes the new value or takes its
// front neighbor's value; on a pop it takes its back neighbor's value.
// ----------------------------------------------------------------------------
module smpq_cell (
  input  logic                clk,
  input  smpq_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  smpq_pkg::cell_link_t front_link,
  input  smpq_pkg::value_t    back_value,
  output smpq_pkg::cell_link_t link,
  output smpq_pkg::value_t    value_nxt
);

  smpq_pkg::value_t value_r;
  logic             greater;

  // An empty cell always accepts the new value or a shifted one.
  assign greater = !occupied || (ctrl.new_value > value_r);

  always_comb begin
    value_nxt = value_r;
    if (ctrl.push_en && greater) begin
      value_nxt = front_link.greater ? front_link.value : ctrl.new_value;
    end else if (ctrl.pop_en) begin
      value_nxt = back_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign link.greater = greater;
  assign link.value   = value_r;

endmodule

>>> rtl/smpq_chain.sv
// ----------------------------------------------------------------------------
// smpq_chain: row of cells holding the queue in descending order
// Wires each cell to its neighbors and derives occupancy per cell.
// ----------------------------------------------------------------------------
module smpq_chain (
  input  logic                          clk,
  input  smpq_pkg::cell_ctrl_t          ctrl,
  input  logic [smpq_pkg::COUNT_W-1:0]  count,
  output smpq_pkg::value_t              head_value,
  output smpq_pkg::value_t              second_value,
  output smpq_pkg::value_t              head_nxt
);

  smpq_pkg::cell_link_t links     [smpq_pkg::DEPTH];
  smpq_pkg::value_t     nxt_values[smpq_pkg::DEPTH];

  for (genvar i = 0; i < smpq_pkg::DEPTH; i++) begin : g_cell
    smpq_pkg::cell_link_t front;
    smpq_pkg::value_t     back;
    logic                 occupied;

    assign occupied = smpq_pkg::COUNT_W'(i) < count;

    if (i == 0) begin : g_first
      assign front.greater = 1'b0;
      assign front.value   = '0;
    end else begin : g_rest
      assign front = links[i-1];
    end

    if (i == smpq_pkg::DEPTH - 1) begin : g_last
      assign back = links[i].value;
    end else begin : g_inner
      assign back = links[i+1].value;
    end

    smpq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occupied),
      .front_link (front),
      .back_value (back),
      .link       (links[i]),
      .value_nxt  (nxt_values[i])
    );
  end

  assign head_value   = links[0].value;
  assign second_value = links[1].value;
  assign head_nxt     = nxt_values[0];

endmodule

>>> rtl/sorted_max_priority_queue_top.sv
// Timing: each result is registered and presented in the cycle after its
// input transfer. Throughput: one operation per cycle while the result
// channel is not stalled; every cell compares and shifts in the same cycle.
// Reset: synchronous active-low rst_n empties the queue and clears the
// output valid; stored values are not cleared and are never read unwritten.
// ----------------------------------------------------------------------------
// sorted_max_priority_queue_top: max-priority queue on a sorted cell chain
// Each input transfer is a push of a signed value or a pop of the largest
// value. Every transfer yields one result with the popped value, the new
// head, the entry count and a status code.
// ----------------------------------------------------------------------------
module sorted_max_priority_queue_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [smpq_pkg::IN_DATA_W-1:0]  in_tdata,   // [VALUE_WIDTH-1:0] value
  input  logic                            in_tuser,   // [0] opcode: 0 push, 1 pop
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0 up: popped_value, head_value, entry_count, status,
  // then zero padding to a whole byte.
  output logic [smpq_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int VW = smpq_pkg::VALUE_WIDTH;
  localparam int CW = smpq_pkg::COUNT_W;

  logic                 accept;
  logic                 is_pop;
  logic                 is_full;
  logic                 is_empty;
  smpq_pkg::cell_ctrl_t ctrl;
  smpq_pkg::value_t     head_value;
  smpq_pkg::value_t     second_value;
  smpq_pkg::value_t     head_nxt;

  logic [CW-1:0]                 count_r, count_nxt;
  logic                          out_valid_r, out_valid_nxt;
  smpq_pkg::value_t              popped_r, popped_nxt;
  smpq_pkg::value_t              head_r, head_out_nxt;
  logic [CW-1:0]                 out_count_r;
  logic [smpq_pkg::STATUS_W-1:0] status_r, status_nxt;

  // The output register parts the two sides: a new transfer is taken
  // whenever the held result leaves in the same cycle or none is held.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign is_pop   = (in_tuser == smpq_pkg::OP_POP);
  assign is_full  = (count_r == CW'(smpq_pkg::DEPTH));
  assign is_empty = (count_r == '0);

  // A push to a full queue and a pop of an empty one leave the cells alone.
  assign ctrl.push_en   = accept && !is_pop && !is_full;
  assign ctrl.pop_en    = accept && is_pop && !is_empty;
  assign ctrl.new_value = in_tdata[VW-1:0];

  smpq_chain u_chain (
    .clk          (clk),
    .ctrl         (ctrl),
    .count        (count_r),
    .head_value   (head_value),
    .second_value (second_value),
    .head_nxt     (head_nxt)
  );

  always_comb begin
    count_nxt = count_r;
    if (ctrl.push_en) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.pop_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Result fields, formed at the input transfer; head from the chain's next state.
  always_comb begin
    popped_nxt   = '0;
    status_nxt   = smpq_pkg::ST_OK;
    head_out_nxt = (count_nxt == '0) ? '0 : head_nxt;
    if (is_pop) begin
      if (is_empty) begin
        status_nxt = smpq_pkg::ST_EMPTY;
      end else begin
        popped_nxt = head_value;
      end
    end else if (is_full) begin
      status_nxt = smpq_pkg::ST_FULL;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r    <= popped_nxt;
      head_r      <= head_out_nxt;
      out_count_r <= count_nxt;
      status_r    <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = smpq_pkg::OUT_DATA_W'({status_r, out_count_r, head_r, popped_r});

`ifndef SYNTHESIS
  // The stored count never goes past the capacity.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(smpq_pkg::DEPTH))
    else $error("entry count exceeds capacity");

  // A pop of a non-empty queue removes exactly one entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_pop && !is_empty |=> count_r == $past(count_r) - CW'(1))
    else $error("pop did not remove one entry");

  // A full status is reported only with the queue at capacity.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == smpq_pkg::ST_FULL |-> out_count_r == CW'(smpq_pkg::DEPTH))
    else $error("full status without a full queue");

  // The two front cells stay in descending order.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CW'(2) |-> head_value >= second_value)
    else $error("front cells out of order");
`endif

endmodule

>>> tb/tb_sorted_max_priority_queue_top.sv
// ----------------------------------------------------------------------------
// tb_sorted_max_priority_queue_top: self-checking bench for the priority queue
// Drives push and pop transfers into the queue and checks every result
// against a sorted-list predictor kept inside the bench or a hand-typed
// row. A short table of directed operations covers the value extremes,
// an empty pop and a full push. Random traffic follows in four idling
// phases, each from a drained block, one with a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_sorted_max_priority_queue_top;

  // One result as it sits in out_tdata; the first member lands in the
  // highest bits, so popped_value ends up at bit 0.
  typedef struct packed {
    logic [smpq_pkg::STATUS_W-1:0] status;
    logic [smpq_pkg::COUNT_W-1:0]  entry_count;
    smpq_pkg::value_t              head_value;
    smpq_pkg::value_t              popped_value;
  } queue_result_t;

  // One row of the directed table. When has_typed is set, the result is
  // written in by hand and checked as given; otherwise the predictor decides.
  typedef struct packed {
    logic             opcode;
    smpq_pkg::value_t value;
    logic             has_typed;
    queue_result_t    typed;
  } op_row_t;

  localparam int            DIRECTED_COUNT = 25;
  localparam int            ITEMS_PER_PHASE = 332;
  localparam int            RUN_LENGTH = 24;      // items between push-mix changes
  localparam int            HOLD_CYCLES = 64;     // long receiver hold-off
  localparam int            DRAIN_CYCLES = 8;     // quiet cycles after the last result
  localparam int            WATCHDOG_LIMIT = 2000;
  localparam queue_result_t PREDICTED = '0;

  localparam smpq_pkg::value_t V_MAX = 32'sh7fff_ffff;
  localparam smpq_pkg::value_t V_MIN = 32'sh8000_0000;

  // The table first pops the empty queue, then fills all sixteen cells with
  // extremes, duplicates and bit patterns, pushes once more into the full
  // queue, and finally pops seven entries back out with junk in the value
  // field, which a pop must ignore.
  localparam op_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{smpq_pkg::OP_POP,  32'sh0000_0000, 1'b1,
      '{smpq_pkg::ST_EMPTY, smpq_pkg::COUNT_W'(0), 32'sh0, 32'sh0}},
    '{smpq_pkg::OP_PUSH, V_MAX,          1'b1,
      '{smpq_pkg::ST_OK, smpq_pkg::COUNT_W'(1), V_MAX, 32'sh0}},
    '{smpq_pkg::OP_PUSH, V_MIN,          1'b0, PREDICTED},
    '{smpq_pkg::OP_PUSH, 32'sh0000_0000, 1'b0, PREDICTED},
    '{smpq_pkg::OP_PUSH, 32'shffff_ffff, 1'b0, PREDICTED},
    '{smpq_pkg::OP_PUSH, 32'sh0000_0001, 1'b0, PREDICTED},
    '{smpq_pkg::OP_PUSH, V_MAX,          1'b0, PREDICTED},
    '{smpq_pkg::OP_PUSH, V_MIN,          1'b0, PREDICTED},
    '{smpq_pkg::OP_PUSH, 32'sh5555_5555, 1'b0, PREDICTED},
    '{smpq_pkg::OP_PUSH, 32'shaaaa_aaaa, 1'b0, PREDICTED},
    '{smpq_pkg::OP_PUSH, 32'sh1234_5678, 1'b0, PREDICTED},
    '{smpq_pkg::OP_PUSH, 32'sh8000_0001, 1'b0, PREDICTED},
    '{smpq_pkg::OP_PUSH, 32'sh7fff_fffe, 1'b0, PREDICTED},
    '{smpq_pkg::OP_PUSH, 32'sh0000_0000, 1'b0, PREDICTED},
    '{smpq_pkg::OP_PUSH, 32'shffff_fffe, 1'b0, PREDICTED},
    '{smpq_pkg::OP_PUSH, 32'sh00ff_00ff, 1'b0, PREDICTED},
    '{smpq_pkg::OP_PUSH, 32'shff00_ff00, 1'b0, PREDICTED},
    '{smpq_pkg::OP_PUSH, 32'sh0000_0003, 1'b1,
      '{smpq_pkg::ST_FULL, smpq_pkg::COUNT_W'(smpq_pkg::DEPTH), V_MAX, 32'sh0}},
    '{smpq_pkg::OP_POP,  32'shffff_ffff, 1'b0, PREDICTED},
    '{smpq_pkg::OP_POP,  32'sh0000_0000, 1'b0, PREDICTED},
    '{smpq_pkg::OP_POP,  32'sh5a5a_a5a5, 1'b0, PREDICTED},
    '{smpq_pkg::OP_POP,  V_MAX,          1'b0, PREDICTED},
    '{smpq_pkg::OP_POP,  V_MIN,          1'b0, PREDICTED},
    '{smpq_pkg::OP_POP,  32'sh0f0f_f0f0, 1'b0, PREDICTED},
    '{smpq_pkg::OP_POP,  32'shffff_ffff, 1'b0, PREDICTED}
  };

  // Bench-side signals. Every input of the block starts at a known value.
  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [smpq_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            in_tuser = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [smpq_pkg::OUT_DATA_W-1:0] out_tdata;

  // Hand-typed expectation that travels with the item being offered.
  logic          typed_valid = 1'b0;
  queue_result_t typed_result = '0;

  // Predictor state: the stored values in descending order and their count.
  smpq_pkg::value_t model_slots [smpq_pkg::DEPTH];
  int unsigned      model_fill = 0;

  // Results still owed by the block, oldest first.
  queue_result_t expected_results [$];
  int unsigned   error_count = 0;

  // Idling controls. The sender sets the rates and asks for the hold-off;
  // the receiver keeps its own count of the hold-off cycles.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_ask = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  sorted_max_priority_queue_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 4-unit clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one operation to the predictor and returns the result the block
  // must produce for it. A push walks past every stored value that is not
  // smaller, so equal values keep their arrival order.
  function automatic queue_result_t apply_queue_op(input logic opcode,
                                                   input smpq_pkg::value_t value);
    queue_result_t res;
    int unsigned   pos;
    int unsigned   i;
    res = '0;
    res.status = smpq_pkg::ST_OK;
    if (opcode == smpq_pkg::OP_PUSH) begin
      if (model_fill >= smpq_pkg::DEPTH) begin
        res.status = smpq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < model_fill && !(value > model_slots[pos])) pos++;
        for (i = model_fill; i > pos; i--) model_slots[i] = model_slots[i-1];
        model_slots[pos] = value;
        model_fill++;
      end
    end else begin
      if (model_fill == 0) begin
        res.status = smpq_pkg::ST_EMPTY;
      end else begin
        res.popped_value = model_slots[0];
        for (i = 0; i + 1 < model_fill; i++) model_slots[i] = model_slots[i+1];
        model_fill--;
      end
    end
    res.head_value  = (model_fill > 0) ? model_slots[0] : '0;
    res.entry_count = smpq_pkg::COUNT_W'(model_fill);
    return res;
  endfunction

  // Random values: mostly full-range words, with a good share of small values
  // around zero so that duplicates are common, plus the two extremes and
  // their neighbors so that the signed ordering is pushed at its edges.
  function automatic smpq_pkg::value_t pick_value();
    case ($urandom_range(7))
      3, 4:    return smpq_pkg::value_t'($urandom_range(8)) - smpq_pkg::value_t'(4);
      5: begin
        case ($urandom_range(3))
          0:       return V_MAX;
          1:       return V_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      6:       return $urandom_range(1) ? V_MAX - smpq_pkg::value_t'($urandom_range(3))
                                        : V_MIN + smpq_pkg::value_t'($urandom_range(3));
      default: return smpq_pkg::value_t'($urandom);
    endcase
  endfunction

  // Offers one operation and returns at the edge where it is transferred.
  // Before the offer the sender may sit idle at random at the current rate;
  // while idle the data lines carry junk that the block must not pick up.
  task automatic send_op(input logic opcode, input smpq_pkg::value_t value,
                         input op_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      in_tuser  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_tvalid    <= 1'b1;
    in_tuser     <= opcode;
    in_tdata     <= value;
    typed_valid  <= row.has_typed;
    typed_result <= row.typed;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drops the valid and waits until the block has returned every result.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Receiver. It stalls at random at the current rate, and when the sender
  // asks for a hold-off it keeps out_tready low for a long hold-off that it
  // counts itself, so that the block fills up and has to stall its input.
  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Scoreboard. A result leaving the block is checked first against the
  // oldest expectation; an input transfer at the same edge then queues its
  // own expectation. A result is registered before it leaves, so the two never
  // belong together, and doing them in one process keeps the order fixed.
  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    queue_result_t predicted;
    if (rst_n && out_tvalid && out_tready) begin
      got = queue_result_t'(out_tdata[smpq_pkg::OUT_FIELDS_W-1:0]);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.popped_value !== want.popped_value) begin
          $display("%0t: popped_value mismatch, expected %h, actual %h",
                   $time, want.popped_value, got.popped_value);
          error_count++;
        end
        if (got.head_value !== want.head_value) begin
          $display("%0t: head_value mismatch, expected %h, actual %h",
                   $time, want.head_value, got.head_value);
          error_count++;
        end
        if (got.entry_count !== want.entry_count) begin
          $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                   $time, want.entry_count, got.entry_count);
          error_count++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, got.status);
          error_count++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      // The predictor always runs so that its state follows the block; a
      // hand-typed row replaces only what is checked.
      predicted = apply_queue_op(in_tuser,
                                 smpq_pkg::value_t'(in_tdata[smpq_pkg::VALUE_WIDTH-1:0]));
      expected_results.push_back(typed_valid ? typed_result : predicted);
    end
  end

  // Watchdog: ends the run if no transfer happens on either side for too long.
  // The longest legal quiet stretch is the receiver hold-off plus a few
  // random gaps, far below the limit.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, expected_results.size());
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence: reset, directed table, four random phases, drain.
  initial begin
    int unsigned row_idx;
    int unsigned phase;
    int unsigned k;
    int unsigned push_pct;
    logic        opcode;

    push_pct = 50;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (row_idx = 0; row_idx < DIRECTED_COUNT; row_idx++) begin
      send_op(DIRECTED_ROWS[row_idx].opcode, DIRECTED_ROWS[row_idx].value,
              DIRECTED_ROWS[row_idx]);
    end

    // Phases: no idling, sender idle, receiver stalling, both. Each phase
    // starts from a drained block: before each one the sender pauses until
    // every result is back.
    for (phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 53; end
        default: begin send_idle_pct = 37; recv_stall_pct <= 37; end
      endcase
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        // Runs of push-heavy, pop-heavy and balanced traffic, so the queue
        // keeps swinging between full and empty instead of hovering mid-way.
        if (k % RUN_LENGTH == 0) begin
          case ($urandom_range(2))
            0:       push_pct = 85;
            1:       push_pct = 15;
            default: push_pct = 50;
          endcase
        end
        // While the sender keeps offering back to back, the receiver holds
        // off for a long stretch.
        if (phase == 0 && k == 100) hold_ask <= hold_ask + 1;
        opcode = ($urandom_range(99) < push_pct) ? smpq_pkg::OP_PUSH : smpq_pkg::OP_POP;
        send_op(opcode, pick_value(), '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/smpq_pkg.sv
rtl/smpq_cell.sv
rtl/smpq_chain.sv
rtl/sorted_max_priority_queue_top.sv
tb/tb_sorted_max_priority_queue_top.sv
